FILE: hw/rtl/dds_pkg.sv
// shared types, field widths and constants of the dds wave generator
package dds_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF  = 24;
  localparam int WAVE_COUNT_DEF  = 4;

  localparam int OP_W       = 1;
  localparam int WAVE_W     = 2;
  localparam int INDEX_W    = 10;
  localparam int CODE_W     = 10;
  localparam int FREQ_W     = 14;
  localparam int SEL_W      = 3;
  localparam int AMP_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_TICK = 1'b1;

  localparam logic [SEL_W-1:0] WAVE_DC     = 3'd0;
  localparam logic [SEL_W-1:0] WAVE_SINE   = 3'd1;
  localparam logic [SEL_W-1:0] WAVE_SQUARE = 3'd2;
  localparam logic [SEL_W-1:0] WAVE_TRI    = 3'd3;
  localparam logic [SEL_W-1:0] WAVE_SAW    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP  = 2'd2;

  localparam int MIDPOINT    = 512;
  localparam int CODE_MAX    = 1023;
  localparam int TUNE_SHIFT  = 8;
  localparam int TUNE_OFFSET = 10;

  // sine divisor breakpoints on amplitude
  localparam int AMP_LOW_MAX  = 13;
  localparam int AMP_MID_MAX  = 60;
  localparam int AMP_HIGH_MIN = 90;

  localparam int DIV_A = 90;
  localparam int DIV_B = 92;
  localparam int DIV_C = 100;

  // ceiling reciprocals, exact for dividends below 2**17
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_A = RECIP_W'(((1 << RECIP_SHIFT) + DIV_A - 1) / DIV_A);
  localparam logic [RECIP_W-1:0] RECIP_B = RECIP_W'(((1 << RECIP_SHIFT) + DIV_B - 1) / DIV_B);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(((1 << RECIP_SHIFT) + DIV_C - 1) / DIV_C);

  typedef enum logic [1:0] {
    DIV_90,
    DIV_92,
    DIV_100
  } div_sel_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [WAVE_W-1:0]  load_wave;
    logic [INDEX_W-1:0] load_index;
    logic [CODE_W-1:0]  load_value;
  } dds_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] sample;
  } dds_out_t;

  function automatic logic [RECIP_W-1:0] recip_of(div_sel_e sel);
    logic [RECIP_W-1:0] r;
    case (sel)
      DIV_90:  r = RECIP_A;
      DIV_92:  r = RECIP_B;
      DIV_100: r = RECIP_C;
      default: r = RECIP_A;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/dds_stream_if.sv
// valid/ready stream channel carrying one payload struct per beat
interface dds_stream_if #(
  parameter type payload_t = dds_pkg::dds_in_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/dds_wave_generator_with_amplitude.sv
// dds source: phase accumulator, four waveform tables, per-sample amplitude scaling
// a tick beat passes the stage 1, stage 2, stage 3 and output registers to give its sample; load beats give none
// throughput is one beat per cycle, set by the single write and single registered read port
// of the table memory; the pipeline stalls only while the output beat waits
// reset clears the phase, the settings and all valid flags; table contents are kept
module dds_wave_generator_with_amplitude #(
  parameter int TABLE_DEPTH = dds_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_BITS  = dds_pkg::PHASE_BITS_DEF,
  parameter int WAVE_COUNT  = dds_pkg::WAVE_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dds_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  dds_stream_if.sink                      in_i,
  dds_stream_if.source                    out_o
);

  localparam int TblAw    = $clog2(TABLE_DEPTH);
  localparam int MemDepth = WAVE_COUNT * TABLE_DEPTH;
  localparam int MemAw    = $clog2(MemDepth);
  localparam int ProdW    = PHASE_BITS + TblAw;
  localparam int OpndW    = 11;
  localparam int MulW     = 19;
  localparam int MagW     = 17;
  localparam int QprodW   = MagW + dds_pkg::RECIP_W;
  localparam int QuotW    = QprodW - dds_pkg::RECIP_SHIFT;
  localparam int SumW     = 13;

  typedef enum logic [1:0] {
    KIND_DC,
    KIND_WAVE,
    KIND_FLAT
  } kind_e;

  // settings
  logic [dds_pkg::FREQ_W-1:0] freq_q;
  logic [dds_pkg::SEL_W-1:0]  sel_q;
  logic [dds_pkg::AMP_W-1:0]  amp_q;

  logic                   advance;
  logic                   in_fire;
  logic                   tick_fire;
  logic                   load_fire;
  logic [PHASE_BITS-1:0]  phase_q;
  logic [PHASE_BITS-1:0]  phase_d;
  logic [PHASE_BITS-1:0]  tune_word;
  logic [ProdW-1:0]       phase_prod;
  logic [TblAw-1:0]       rd_idx;
  logic [dds_pkg::SEL_W-1:0] rd_wave;
  logic [MemAw-1:0]       rd_addr;
  logic [MemAw-1:0]       wr_addr;
  logic                   wr_ok;
  logic                   sel_ok;
  kind_e                  kind_d;
  dds_pkg::div_sel_e      div_d;

  logic [dds_pkg::CODE_W-1:0] wave_mem [MemDepth];

  // pipeline
  logic                        s1_valid_q;
  kind_e                       s1_kind_q;
  dds_pkg::div_sel_e           s1_div_q;
  logic [dds_pkg::CODE_W-1:0]  rd_data_q;
  logic signed [OpndW-1:0]     s1_opnd;
  logic signed [MulW-1:0]      s1_prod;
  logic [MagW-1:0]             s1_mag;

  logic                        s2_valid_q;
  kind_e                       s2_kind_q;
  dds_pkg::div_sel_e           s2_div_q;
  logic [MagW-1:0]             s2_mag_q;
  logic                        s2_neg_q;
  logic [QprodW-1:0]           s2_qprod;

  logic                        s3_valid_q;
  kind_e                       s3_kind_q;
  logic [QuotW-1:0]            s3_quot_q;
  logic                        s3_neg_q;
  logic signed [SumW-1:0]      s3_sum;
  logic [dds_pkg::CODE_W-1:0]  s3_code;

  logic                        out_valid_q;
  logic [dds_pkg::CODE_W-1:0]  out_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= '0;
      sel_q  <= '0;
      amp_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dds_pkg::CFG_FREQ: freq_q <= cfg_wdata_i[dds_pkg::FREQ_W-1:0];
        dds_pkg::CFG_WAVE: sel_q  <= cfg_wdata_i[dds_pkg::SEL_W-1:0];
        dds_pkg::CFG_AMP:  amp_q  <= cfg_wdata_i[dds_pkg::AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;
  assign in_fire    = in_i.valid && advance;
  assign tick_fire  = in_fire && (in_i.data.operation == dds_pkg::OP_TICK);
  assign load_fire  = in_fire && (in_i.data.operation == dds_pkg::OP_LOAD);

  // phase step and table address of the new phase
  assign tune_word  = PHASE_BITS'((32'(freq_q) << dds_pkg::TUNE_SHIFT)
                                  + 32'(dds_pkg::TUNE_OFFSET));
  assign phase_d    = phase_q + tune_word;
  assign phase_prod = ProdW'(phase_d) * ProdW'(TABLE_DEPTH);
  assign rd_idx     = phase_prod[ProdW-1:PHASE_BITS];
  assign rd_wave    = sel_q - dds_pkg::SEL_W'(1);
  assign rd_addr    = MemAw'(32'(rd_wave) * 32'(TABLE_DEPTH) + 32'(rd_idx));

  assign sel_ok = (sel_q != dds_pkg::WAVE_DC) && (sel_q <= dds_pkg::WAVE_SAW)
                  && (32'(sel_q) <= 32'(WAVE_COUNT));

  assign wr_addr = MemAw'(32'(in_i.data.load_wave) * 32'(TABLE_DEPTH)
                          + 32'(in_i.data.load_index));
  assign wr_ok   = (32'(in_i.data.load_wave) < 32'(WAVE_COUNT))
                   && (32'(in_i.data.load_index) < 32'(TABLE_DEPTH));

  always_comb begin
    if (sel_q == dds_pkg::WAVE_DC) begin
      kind_d = KIND_DC;
    end else if (sel_ok) begin
      kind_d = KIND_WAVE;
    end else begin
      kind_d = KIND_FLAT;
    end
    div_d = dds_pkg::DIV_90;
    if (sel_q == dds_pkg::WAVE_SINE) begin
      if (32'(amp_q) <= 32'(dds_pkg::AMP_LOW_MAX)) begin
        div_d = dds_pkg::DIV_90;
      end else if (32'(amp_q) <= 32'(dds_pkg::AMP_MID_MAX)) begin
        div_d = dds_pkg::DIV_92;
      end else if (32'(amp_q) < 32'(dds_pkg::AMP_HIGH_MIN)) begin
        div_d = dds_pkg::DIV_90;
      end else begin
        div_d = dds_pkg::DIV_100;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (tick_fire) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_fire && wr_ok) begin
      wave_mem[wr_addr] <= in_i.data.load_value;
    end
    if (tick_fire && sel_ok) begin
      rd_data_q <= wave_mem[rd_addr];
    end
  end

  // stage 1: center the entry (dc takes full scale instead) and scale by amplitude
  always_comb begin
    if (s1_kind_q == KIND_DC) begin
      s1_opnd = OpndW'(dds_pkg::CODE_MAX);
    end else begin
      s1_opnd = $signed({1'b0, rd_data_q}) - OpndW'(dds_pkg::MIDPOINT);
    end
    s1_prod = MulW'(s1_opnd) * MulW'($signed({1'b0, amp_q}));
    s1_mag  = (s1_prod < 0) ? MagW'(-s1_prod) : MagW'(s1_prod);
  end

  // stage 2: divide the magnitude by reciprocal multiply
  assign s2_qprod = QprodW'(s2_mag_q) * QprodW'(dds_pkg::recip_of(s2_div_q));

  // stage 3: restore sign and recenter (dc is not recentered, an unused select gives the midpoint), then saturate
  always_comb begin
    case (s3_kind_q)
      KIND_DC:   s3_sum = SumW'(s3_quot_q);
      KIND_WAVE: s3_sum = s3_neg_q ? SumW'(dds_pkg::MIDPOINT) - SumW'(s3_quot_q)
                                   : SumW'(dds_pkg::MIDPOINT) + SumW'(s3_quot_q);
      default:   s3_sum = SumW'(dds_pkg::MIDPOINT);
    endcase
    if (s3_sum < 0) begin
      s3_code = '0;
    end else if (s3_sum > SumW'(dds_pkg::CODE_MAX)) begin
      s3_code = dds_pkg::CODE_W'(dds_pkg::CODE_MAX);
    end else begin
      s3_code = s3_sum[dds_pkg::CODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= tick_fire;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_kind_q    <= kind_d;
      s1_div_q     <= div_d;
      s2_kind_q    <= s1_kind_q;
      s2_div_q     <= s1_div_q;
      s2_mag_q     <= s1_mag;
      s2_neg_q     <= s1_prod < 0;
      s3_kind_q    <= s2_kind_q;
      s3_quot_q    <= s2_qprod[QprodW-1:dds_pkg::RECIP_SHIFT];
      s3_neg_q     <= s2_neg_q;
      out_sample_q <= s3_code;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data.sample = out_sample_q;

  a_load_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> !s1_valid_q)
    else $error("load beat entered the sample pipeline");

  a_tick_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> s1_valid_q)
    else $error("tick beat lost at pipeline entry");

  a_phase_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_fire |=> $stable(phase_q))
    else $error("phase moved without a tick beat");

  a_flat_mid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s3_valid_q && s3_kind_q == KIND_FLAT)
    |=> out_o.data.sample == dds_pkg::CODE_W'(dds_pkg::MIDPOINT))
    else $error("unused wave select did not give midpoint");

endmodule

FILE: tb/dds_sample_checker.sv
// checker: mirrors the dds state from observed settings writes and beats and compares every sample beat
`timescale 1ns / 100ps
module dds_sample_checker
  import dds_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  dds_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  dds_out_t              out_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int ADDR_W      = $clog2(TABLE_DEPTH_DEF);
  localparam int MAX_REPORTS = 10;

  logic [CODE_W-1:0]         wave_mem [WAVE_COUNT_DEF][TABLE_DEPTH_DEF];
  logic [PHASE_BITS_DEF-1:0] phase_acc;
  logic [FREQ_W-1:0]         freq_q;
  logic [SEL_W-1:0]          sel_q;
  logic [AMP_W-1:0]          amp_q;
  logic [CODE_W-1:0]         sample_due_q [$];
  int                        mismatch_cnt;
  int                        sample_cnt;

  function automatic int clamp_code(int v);
    if (v < 0) return 0;
    if (v > CODE_MAX) return CODE_MAX;
    return v;
  endfunction

  function automatic logic [CODE_W-1:0] predict_sample(logic [SEL_W-1:0] sel,
                                                       logic [AMP_W-1:0] amp,
                                                       logic [CODE_W-1:0] entry);
    int centered;
    int divisor;
    if (sel == WAVE_DC) return CODE_W'(clamp_code((CODE_MAX * int'(amp)) / DIV_A));
    if (sel > WAVE_SAW) return CODE_W'(MIDPOINT);
    centered = int'(entry) - MIDPOINT;
    divisor  = DIV_A;
    // sine gets its own divisor per amplitude band
    if (sel == WAVE_SINE) begin
      if (amp <= AMP_LOW_MAX) divisor = DIV_A;
      else if (amp <= AMP_MID_MAX) divisor = DIV_B;
      else if (amp < AMP_HIGH_MIN) divisor = DIV_A;
      else divisor = DIV_C;
    end
    return CODE_W'(clamp_code(centered * int'(amp) / divisor + MIDPOINT));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : observe
    logic [CODE_W-1:0] entry;
    logic [CODE_W-1:0] want;
    if (!rst_ni) begin
      phase_acc    = '0;
      freq_q       = '0;
      sel_q        = '0;
      amp_q        = '0;
      mismatch_cnt = 0;
      sample_cnt   = 0;
      sample_due_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (sample_due_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("sample beat %0d arrived with none expected: got %0d",
                     sample_cnt, out_data_i.sample);
        end else begin
          want = sample_due_q.pop_front();
          if (out_data_i.sample !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("sample beat %0d mismatch: expected %0d, got %0d",
                       sample_cnt, want, out_data_i.sample);
          end
        end
        sample_cnt++;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FREQ: freq_q = cfg_wdata_i[FREQ_W-1:0];
          CFG_WAVE: sel_q  = cfg_wdata_i[SEL_W-1:0];
          CFG_AMP:  amp_q  = cfg_wdata_i[AMP_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        if (in_data_i.operation == OP_LOAD) begin
          wave_mem[in_data_i.load_wave][in_data_i.load_index] = in_data_i.load_value;
        end else begin
          phase_acc = phase_acc + (PHASE_BITS_DEF'(freq_q) << TUNE_SHIFT)
                    + PHASE_BITS_DEF'(TUNE_OFFSET);
          entry = '0;
          if (sel_q >= WAVE_SINE && sel_q <= WAVE_SAW)
            entry = wave_mem[WAVE_W'(sel_q - WAVE_SINE)]
                            [phase_acc[PHASE_BITS_DEF-1 -: ADDR_W]];
          sample_due_q.push_back(predict_sample(sel_q, amp_q, entry));
        end
      end
    end
    fail_count_o = mismatch_cnt;
    pending_o    = sample_due_q.size();
  end

endmodule

FILE: tb/dds_wave_generator_with_amplitude_tb.sv
// bench top for the dds generator: clock, reset, settings, beat stimulus and verdict
`timescale 1ns / 100ps
module dds_wave_generator_with_amplitude_tb;
  import dds_pkg::*;

  localparam int ADDR_W       = $clog2(TABLE_DEPTH_DEF);
  localparam int RANDOM_BEATS = 1300;
  localparam int LONG_HOLD    = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [WAVE_W-1:0] TBL_SINE   = 2'd0;
  localparam logic [WAVE_W-1:0] TBL_SQUARE = 2'd1;
  localparam logic [WAVE_W-1:0] TBL_TRI    = 2'd2;
  localparam logic [WAVE_W-1:0] TBL_SAW    = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    beats_sent;
  int                    cycle_cnt;
  bit                    calm;
  bit                    long_hold_req;

  // settings and phase as the stimulus sees them, to keep every table read on a written entry
  logic [FREQ_W-1:0]         cur_freq;
  logic [SEL_W-1:0]          cur_sel;
  logic [PHASE_BITS_DEF-1:0] stim_phase;
  bit [TABLE_DEPTH_DEF-1:0]  written [WAVE_COUNT_DEF];

  dds_stream_if #(.payload_t(dds_in_t))  in_ch ();
  dds_stream_if #(.payload_t(dds_out_t)) out_ch ();

  dds_wave_generator_with_amplitude u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  dds_sample_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("dds_wave_generator_with_amplitude_tb: FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [CODE_W-1:0] rand_code();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      2: return CODE_W'(MIDPOINT);
      default: return CODE_W'($urandom_range(CODE_MAX));
    endcase
  endfunction

  // receiver pacing, with one long hold on request
  initial begin : sink_pacing
    int stall_left;
    int run_left;
    stall_left   = 0;
    run_left     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && stall_left == 0) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end else if (stall_left == 0 && run_left == 0) begin
        run_left   = $urandom_range(24, 1);
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (run_left > 0) run_left--;
      end
    end
  end

  // all tasks start and end at a falling edge
  task automatic send_beat(input dds_in_t beat);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= beat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(input logic [WAVE_W-1:0] wave, input logic [INDEX_W-1:0] index,
                           input logic [CODE_W-1:0] value);
    dds_in_t beat;
    beat.operation  = OP_LOAD;
    beat.load_wave  = wave;
    beat.load_index = index;
    beat.load_value = value;
    written[wave][index] = 1'b1;
    send_beat(beat);
  endtask

  task automatic send_tick();
    dds_in_t                   beat;
    logic [PHASE_BITS_DEF-1:0] next_phase;
    logic [ADDR_W-1:0]         addr;
    next_phase = stim_phase + (PHASE_BITS_DEF'(cur_freq) << TUNE_SHIFT)
               + PHASE_BITS_DEF'(TUNE_OFFSET);
    addr = next_phase[PHASE_BITS_DEF-1 -: ADDR_W];
    // fill the entry this tick will read if nothing was loaded there yet
    if (cur_sel >= WAVE_SINE && cur_sel <= WAVE_SAW
        && !written[WAVE_W'(cur_sel - WAVE_SINE)][addr])
      send_load(WAVE_W'(cur_sel - WAVE_SINE), addr, rand_code());
    beat.operation  = OP_TICK;
    beat.load_wave  = WAVE_W'($urandom);
    beat.load_index = INDEX_W'($urandom);
    beat.load_value = CODE_W'($urandom);
    send_beat(beat);
    stim_phase = next_phase;
  endtask

  task automatic apply_settings(input logic [FREQ_W-1:0] freq, input logic [SEL_W-1:0] sel,
                                input logic [AMP_W-1:0] amp, input bit poke_unused);
    cfg_we <= 1'b1;
    if (poke_unused) begin
      cfg_idx   <= CFG_UNUSED;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(negedge clk);
    end
    cfg_idx   <= CFG_FREQ;
    cfg_wdata <= CFG_DATA_W'(freq);
    @(negedge clk);
    cfg_idx   <= CFG_WAVE;
    cfg_wdata <= CFG_DATA_W'(sel);
    @(negedge clk);
    cfg_idx   <= CFG_AMP;
    cfg_wdata <= CFG_DATA_W'(amp);
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_freq = freq;
    cur_sel  = sel;
  endtask

  // stop offering, wait for every sample, then wait out the drain period
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic tick_with(input logic [FREQ_W-1:0] freq, input logic [SEL_W-1:0] sel,
                           input logic [AMP_W-1:0] amp);
    settle();
    apply_settings(freq, sel, amp, 1'b0);
    send_tick();
  endtask

  initial begin : stimulus
    int                n;
    int                phase_no;
    int                stop_at;
    logic [FREQ_W-1:0] freq;
    logic [SEL_W-1:0]  sel;
    logic [AMP_W-1:0]  amp;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cur_freq    = '0;
    cur_sel     = WAVE_DC;
    stim_phase  = '0;
    beats_sent  = 0;
    calm        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // settings straight out of reset: dc at zero amplitude
    send_tick();
    send_load(TBL_SINE, '0, '1);
    send_load(TBL_SQUARE, '0, '0);
    send_load(TBL_TRI, '0, CODE_W'(MIDPOINT));
    send_load(TBL_SAW, '0, 10'd300);
    send_load(TBL_SAW, '1, '1);
    send_load(TBL_SINE, '1, '0);
    settle();
    apply_settings('0, WAVE_DC, 7'd127, 1'b1);
    send_tick();
    // sine divisor bands and their edges, then square and triangle
    tick_with('0, WAVE_SINE, 7'd13);
    tick_with('0, WAVE_SINE, 7'd14);
    tick_with('0, WAVE_SINE, 7'd60);
    tick_with('0, WAVE_SINE, 7'd61);
    tick_with('0, WAVE_SINE, 7'd89);
    tick_with('0, WAVE_SINE, 7'd90);
    tick_with('0, WAVE_SINE, 7'd127);
    tick_with('0, WAVE_SQUARE, 7'd127);
    tick_with('0, WAVE_TRI, 7'd50);
    // negative scaled value truncates toward zero
    tick_with('0, WAVE_SAW, 7'd100);
    tick_with('0, 3'd5, 7'd100);
    tick_with('0, 3'd7, 7'd40);
    tick_with('1, WAVE_SINE, 7'd100);
    tick_with(14'd10000, WAVE_SAW, '0);
    tick_with('1, WAVE_DC, '0);

    stop_at  = beats_sent + RANDOM_BEATS;
    phase_no = 0;
    while (beats_sent < stop_at) begin
      settle();
      calm = ($urandom_range(4) == 0);
      case ($urandom_range(3))
        0: freq = FREQ_W'($urandom_range(20));
        1: begin
          case ($urandom_range(2))
            0: freq = '0;
            1: freq = 14'd10000;
            default: freq = '1;
          endcase
        end
        default: freq = FREQ_W'($urandom);
      endcase
      if ($urandom_range(9) < 7) sel = SEL_W'($urandom_range(WAVE_SAW, WAVE_SINE));
      else sel = SEL_W'($urandom);
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(8))
          0: amp = '0;
          1: amp = AMP_W'(AMP_LOW_MAX);
          2: amp = AMP_W'(AMP_LOW_MAX + 1);
          3: amp = AMP_W'(AMP_MID_MAX);
          4: amp = AMP_W'(AMP_MID_MAX + 1);
          5: amp = AMP_W'(AMP_HIGH_MIN - 1);
          6: amp = AMP_W'(AMP_HIGH_MIN);
          7: amp = 7'd100;
          default: amp = '1;
        endcase
      end else begin
        amp = AMP_W'($urandom);
      end
      apply_settings(freq, sel, amp, 1'b0);
      // one phase where the receiver holds off while the sender keeps offering
      if (phase_no == 2) begin
        calm          = 1'b1;
        long_hold_req = 1'b1;
      end
      n = $urandom_range(60, 10);
      repeat (n) begin
        if ($urandom_range(4) == 0)
          send_load(WAVE_W'($urandom), INDEX_W'($urandom), rand_code());
        else
          send_tick();
      end
      phase_no++;
    end

    settle();
    if (fail_count == 0) begin
      $display("dds_wave_generator_with_amplitude_tb: PASS");
    end else begin
      $display("dds_wave_generator_with_amplitude_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/dds_pkg.sv
hw/rtl/dds_stream_if.sv
hw/rtl/dds_wave_generator_with_amplitude.sv
tb/dds_sample_checker.sv
tb/dds_wave_generator_with_amplitude_tb.sv
